// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the port-level checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: sv/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// shared types and constants of the greatest common divisor block
// ----------------------------------------------------------------------------
package gcd_pkg;

	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_HALVE_BOTH,
		OP_HALVE_A,
		OP_HALVE_B,
		OP_SUB_A,
		OP_SUB_B,
		OP_FINISH
	} op_t;

	typedef struct packed {
		logic done;
		logic a_even;
		logic b_even;
		logic a_ge_b;
	} status_t;

endpackage

// File: sv/gcd_ctrl.sv
// ----------------------------------------------------------------------------
// gcd_ctrl
// controller: sequences load, binary reduction steps and result capture
// ----------------------------------------------------------------------------
module gcd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  gcd_pkg::status_t status,
	output gcd_pkg::op_t     op
);
	import gcd_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   can_finish;

	assign can_finish = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (op == OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_next = ST_RUN;
				end
			end
			ST_RUN: begin
				if (status.done && can_finish) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		op = OP_HOLD;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					op = OP_LOAD;
				end
			end
			ST_RUN: begin
				if (status.done) begin
					op = can_finish ? OP_FINISH : OP_HOLD;
				end else if (status.a_even && status.b_even) begin
					op = OP_HALVE_BOTH;
				end else if (status.a_even) begin
					op = OP_HALVE_A;
				end else if (status.b_even) begin
					op = OP_HALVE_B;
				end else if (status.a_ge_b) begin
					op = OP_SUB_A;
				end else begin
					op = OP_SUB_B;
				end
			end
			default: op = OP_HOLD;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

endmodule

// File: sv/gcd_datapath.sv
// ----------------------------------------------------------------------------
// gcd_datapath
// operand registers, shift and subtract unit, common power of two count
// ----------------------------------------------------------------------------
module gcd_datapath #(
	parameter int DATA_WIDTH = gcd_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic [DATA_WIDTH-1:0] first_value,
	input  logic [DATA_WIDTH-1:0] second_value,
	input  gcd_pkg::op_t          op,
	output gcd_pkg::status_t      status,
	output logic [DATA_WIDTH-1:0] divisor
);
	import gcd_pkg::*;

	localparam int KW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

	logic [DATA_WIDTH-1:0] a_q;
	logic [DATA_WIDTH-1:0] b_q;
	logic [KW-1:0]         k_q;
	logic [DATA_WIDTH-1:0] result_q;
	logic [DATA_WIDTH-1:0] mag_first;
	logic [DATA_WIDTH-1:0] mag_second;
	logic [DATA_WIDTH-1:0] merged;
	logic [DATA_WIDTH-1:0] scaled;

	assign mag_first  = first_value[DATA_WIDTH-1] ? (~first_value + 1'b1) : first_value;
	assign mag_second = second_value[DATA_WIDTH-1] ? (~second_value + 1'b1) : second_value;

	assign merged = a_q | b_q;
	assign scaled = merged << k_q;

	assign status.done   = (a_q == '0) || (b_q == '0);
	assign status.a_even = !a_q[0];
	assign status.b_even = !b_q[0];
	assign status.a_ge_b = (a_q >= b_q);

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				a_q <= mag_first;
				b_q <= mag_second;
				k_q <= '0;
			end
			OP_HALVE_BOTH: begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end
			OP_HALVE_A: a_q <= a_q >> 1;
			OP_HALVE_B: b_q <= b_q >> 1;
			OP_SUB_A:   a_q <= a_q - b_q;
			OP_SUB_B:   b_q <= b_q - a_q;
			OP_FINISH: begin
				result_q <= (merged == '0) ? DATA_WIDTH'(1) : scaled;
			end
			default: ;
		endcase
	end

	assign divisor = result_q;

endmodule

// File: sv/greatest_common_divisor.sv
// ----------------------------------------------------------------------------
// greatest_common_divisor
// greatest common divisor of two signed operands, binary reduction
// ----------------------------------------------------------------------------
// Takes the magnitudes of both operands and reduces them one step per clock
// in a shared shift/subtract unit: strip common factors of two, halve an even
// operand, or subtract the smaller odd operand from the larger. The count of
// shift and subtract steps is set by the bit lengths of the operands, and an
// operand of zero needs none. Both operands zero give 1. The input is taken
// again once the result sits in the output register, so the next item starts
// while that result waits to be read.
module greatest_common_divisor #(
	parameter int DATA_WIDTH = gcd_pkg::DATA_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// first_value, second_value, zero padding
	input  logic [8*((2*DATA_WIDTH+7)/8)-1:0]       s_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// divisor, zero padding
	output logic [8*((DATA_WIDTH+7)/8)-1:0]         m_tdata
);
	import gcd_pkg::*;

	localparam int OUT_BITS = 8 * ((DATA_WIDTH + 7) / 8);

	op_t                   op;
	status_t               status;
	logic [DATA_WIDTH-1:0] divisor;

	gcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.op       (op)
	);

	gcd_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk          (clk),
		.first_value  (s_tdata[DATA_WIDTH-1:0]),
		.second_value (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
		.op           (op),
		.status       (status),
		.divisor      (divisor)
	);

	assign m_tdata = OUT_BITS'(divisor);

endmodule

// File: sv/gcd_checker.sv
// ----------------------------------------------------------------------------
// gcd_checker
// port-level checks of the greatest common divisor block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcd_checker #(
	parameter int DATA_WIDTH = gcd_pkg::DATA_WIDTH_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [8*((2*DATA_WIDTH+7)/8)-1:0] s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [8*((DATA_WIDTH+7)/8)-1:0]   m_tdata
);

	// stalled output transaction holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// accepted input transaction blocks the next one
	`ASSERT_NEXT(a_in_busy, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// divisor is never zero
	`ASSERT_IMPLIES(a_nonzero, clk, arst_n, m_tvalid, m_tdata[DATA_WIDTH-1:0] != '0)
	// divisor never exceeds the largest magnitude
	`ASSERT_IMPLIES(a_range, clk, arst_n, m_tvalid && m_tdata[DATA_WIDTH-1],
		m_tdata[DATA_WIDTH-2:0] == '0)

endmodule

bind greatest_common_divisor gcd_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_gcd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: sim/gcd_checker.sv
// ----------------------------------------------------------------------------
// gcd_scoreboard
// watches both streams of the divisor block and checks every result
// ----------------------------------------------------------------------------
// Each operand pair taken at the input is turned into the expected divisor
// and queued. Each result read at the output is compared with the oldest
// queued divisor. The counters are handed to the testbench top.
module gcd_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// first_value, second_value
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// divisor
	input  logic [31:0] m_tdata,
	output int          mismatches,
	output int          pairs_taken,
	output int          divisors_read
);

	localparam int W = gcd_pkg::DATA_WIDTH_DEF;

	typedef struct {
		logic [W-1:0] first_value;
		logic [W-1:0] second_value;
		logic [W-1:0] divisor;
	} pending_divisor_t;

	pending_divisor_t pending_divisors[$];

	function automatic logic [W-1:0] divisor_of(logic [W-1:0] first_value,
		logic [W-1:0] second_value);
		logic [W-1:0] x;
		logic [W-1:0] y;
		logic [W-1:0] r;
		x = first_value[W-1] ? -first_value : first_value;
		y = second_value[W-1] ? -second_value : second_value;
		if (x < y) begin
			r = x;
			x = y;
			y = r;
		end
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		if (x == 0)
			x = 1;
		return x;
	endfunction

	initial begin
		mismatches    = 0;
		pairs_taken   = 0;
		divisors_read = 0;
	end

	always @(posedge clk) begin
		pending_divisor_t head;
		pending_divisor_t entry;
		if (arst_n) begin
			// output side first: a result never belongs to a pair taken at the same edge
			if (m_tvalid && m_tready) begin
				divisors_read <= divisors_read + 1;
				if (pending_divisors.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: divisor %0d read with no transaction pending",
							$realtime, m_tdata);
				end else begin
					head = pending_divisors.pop_front();
					if (m_tdata !== head.divisor) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: gcd(%0d, %0d) expected %0d, got %0d",
								$realtime, $signed(head.first_value),
								$signed(head.second_value), head.divisor, m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				pairs_taken <= pairs_taken + 1;
				entry.first_value  = s_tdata[W-1:0];
				entry.second_value = s_tdata[2*W-1:W];
				entry.divisor      = divisor_of(entry.first_value, entry.second_value);
				pending_divisors.push_back(entry);
			end
		end
	end

endmodule

// File: sim/tb_greatest_common_divisor.sv
// ----------------------------------------------------------------------------
// tb_greatest_common_divisor
// stimulus and verdict for the greatest common divisor block
// ----------------------------------------------------------------------------
// Sends a directed set of operand pairs (zeros, most negative and largest
// values, mixed signs, Fibonacci worst case), then random pairs weighted
// toward shared factors, powers of two and extremes. Both sides idle at
// random, with one quiet stretch, and the output side holds off once for a
// long stretch so the block backs up. Results are checked by gcd_scoreboard.
module tb_greatest_common_divisor;

	localparam int  W              = gcd_pkg::DATA_WIDTH_DEF;
	localparam int  RANDOM_PAIRS   = 1850;
	localparam int  HOLD_OFF_COUNT = 300;
	localparam int  STALL_LIMIT    = 4000;
	localparam int  DRAIN_CYCLES   = 140;
	localparam int  DIRECTED_COUNT = 20;

	localparam logic [W-1:0] MOST_NEG = 32'h8000_0000;
	localparam logic [W-1:0] MOST_POS = 32'h7fff_ffff;

	localparam logic [W-1:0] DIRECTED_FIRST [DIRECTED_COUNT] = '{
		32'd0, 32'd0, 32'd7, MOST_NEG, 32'd0,
		MOST_NEG, MOST_NEG, MOST_POS, 32'hffff_ffff, 32'd1,
		32'd12, 32'hffff_fff4, 32'd18, MOST_POS, MOST_NEG,
		MOST_POS, 32'd1836311903, 32'hffff_0000, 32'd0, 32'haaaa_aaaa
	};
	localparam logic [W-1:0] DIRECTED_SECOND [DIRECTED_COUNT] = '{
		32'd0, 32'd5, 32'd0, 32'd0, MOST_NEG,
		MOST_NEG, MOST_POS, MOST_POS, 32'hffff_ffff, 32'hffff_ffff,
		32'd18, 32'd18, 32'hffff_fff4, 32'd1, 32'd6,
		32'h7fff_fffe, 32'd1134903170, 32'd4096, 32'hffff_ffff, 32'h5555_5555
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	int mismatches;
	int pairs_taken;
	int divisors_read;
	int pairs_offered;
	int stall_cycles;

	greatest_common_divisor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	gcd_scoreboard checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.mismatches    (mismatches),
		.pairs_taken   (pairs_taken),
		.divisors_read (divisors_read)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic [W-1:0] random_sign(logic [W-1:0] value);
		return $urandom_range(1) ? -value : value;
	endfunction

	function automatic logic [W-1:0] pick_extreme();
		case ($urandom_range(4))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hffff_ffff;
			3: return MOST_POS;
			default: return MOST_NEG;
		endcase
	endfunction

	task automatic make_pair(output logic [W-1:0] first_value,
		output logic [W-1:0] second_value);
		logic [W-1:0] factor;
		logic [W-1:0] fib_lo;
		logic [W-1:0] fib_hi;
		logic [W-1:0] fib_next;
		int           steps;
		case ($urandom_range(7))
			0, 1: begin
				first_value  = $urandom;
				second_value = $urandom;
			end
			2, 3: begin
				factor       = $urandom_range(1, 65535) >> $urandom_range(15);
				first_value  = random_sign(factor * $urandom_range(0, 32767));
				second_value = random_sign(factor * $urandom_range(0, 32767));
			end
			4: begin
				first_value  = $urandom_range(1) ? pick_extreme() : $urandom;
				second_value = 32'd0;
				if ($urandom_range(1)) begin
					second_value = first_value;
					first_value  = 32'd0;
				end
			end
			5: begin
				first_value  = pick_extreme();
				second_value = $urandom_range(1) ? pick_extreme() : $urandom;
			end
			6: begin
				first_value  = random_sign(((2 * $urandom_range(0, 255)) + 1) <<
					$urandom_range(23));
				second_value = random_sign(32'd1 << $urandom_range(31));
			end
			default: begin
				if ($urandom_range(1)) begin
					fib_lo = 32'd1;
					fib_hi = 32'd1;
					steps  = $urandom_range(1, 44);
					for (int i = 0; i < steps; i++) begin
						fib_next = fib_lo + fib_hi;
						fib_lo   = fib_hi;
						fib_hi   = fib_next;
					end
					first_value  = random_sign(fib_hi);
					second_value = random_sign(fib_lo);
				end else begin
					first_value  = $urandom;
					second_value = first_value + $urandom_range(0, 64) - 32;
				end
			end
		endcase
	endtask

	task automatic send_pair(logic [W-1:0] first_value, logic [W-1:0] second_value,
		bit quiet);
		s_tdata  <= {second_value, first_value};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		pairs_offered++;
		if (!quiet && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// output side: random back-pressure, one quiet stretch, one long hold-off
	initial begin
		int  results_seen;
		bit  held;
		results_seen = 0;
		held         = 1'b0;
		m_tready     = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && results_seen >= 500) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_COUNT) @(posedge clk);
			end else begin
				m_tready <= (results_seen >= 800 && results_seen < 1200) ||
					$urandom_range(99) >= 15;
				@(posedge clk);
				if (m_tvalid && m_tready)
					results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("no transaction for %0d cycles", STALL_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		logic [W-1:0] first_value;
		logic [W-1:0] second_value;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		stall_cycles  = 0;
		pairs_offered = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIRECTED_COUNT; i++)
			send_pair(DIRECTED_FIRST[i], DIRECTED_SECOND[i], 1'b0);
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			make_pair(first_value, second_value);
			send_pair(first_value, second_value, i >= 700 && i < 1100);
		end
		s_tvalid <= 1'b0;
		while (pairs_taken != divisors_read || pairs_taken != pairs_offered)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d operand pairs taken, %0d divisors checked, %0d mismatches",
			pairs_taken, divisors_read, mismatches);
		$display("covered zeros, most negative and largest operands, mixed signs, shared factors");
		if (mismatches == 0 && pairs_taken == divisors_read)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
